// ===== sv/aptr_pkg.sv =====
`default_nettype none

package aptr_pkg;

    // Field and datapath widths.
    localparam int unsigned COEF_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned NUM_W  = 66;
    localparam int unsigned QW     = 33;
    localparam int unsigned LANES  = 8;
    localparam int unsigned CFG_W  = 14;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned START_W = 13;
    localparam int unsigned COUNT_W = 14;

    localparam int unsigned MAX_LEVEL_DIM_DEF = 8192;
    localparam logic [CFG_W-1:0] LEVEL_RESET = 14'd1024;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_LEVEL_WIDTH  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_LEVEL_HEIGHT = 8'd1;

    localparam logic signed [COEF_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] Q16_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic valid;
        logic sing;
    } div_ctl_t;

    typedef struct packed {
        logic              nneg;
        logic [PROD_W-1:0] mag;
    } num_t;

endpackage

`default_nettype wire

// ===== sv/aptr_div.sv =====
`default_nettype none

// Eight-lane pipelined restoring divider, one quotient bit per stage.
// Each lane gives floor(num * 2^16 / det) saturated to signed Q16.16.
module aptr_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire aptr_pkg::div_ctl_t            ctl_in,
    input  wire logic [aptr_pkg::PROD_W-1:0]   dabs,
    input  wire logic                          dneg,
    input  wire aptr_pkg::num_t                num_in [aptr_pkg::LANES],
    output aptr_pkg::div_ctl_t                 ctl_out,
    output logic signed [aptr_pkg::COEF_W-1:0] quot [aptr_pkg::LANES]
);

    localparam int unsigned QW = aptr_pkg::QW;
    localparam int unsigned PW = aptr_pkg::PROD_W;
    localparam int unsigned LN = aptr_pkg::LANES;
    localparam int unsigned CW = aptr_pkg::COEF_W;

    logic [QW:0]   v_reg;
    logic [QW:0]   sing_reg;
    logic [PW-1:0] d_reg   [QW+1];
    logic [PW-1:0] r_reg   [QW+1][LN];
    logic [QW-1:0] lo_reg  [QW+1][LN];
    logic [QW-1:0] q_reg   [QW+1][LN];
    logic          neg_reg [QW+1][LN];
    logic          ovf_reg [QW+1][LN];

    aptr_pkg::div_ctl_t      ctl_reg;
    logic signed [CW-1:0]    quot_reg [LN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:0], ctl_in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sing_reg <= {sing_reg[QW-1:0], ctl_in.sing};
            d_reg[0] <= dabs;
        end
    end

    // Setup: the quotient overflows 33 bits when mag >= det * 2^17.
    for (genvar l = 0; l < LN; l++) begin : g_setup
        logic ovf_next;
        assign ovf_next = {17'b0, num_in[l].mag} >= {dabs, 17'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[0][l] <= ovf_next;
                r_reg[0][l]   <= {17'b0, num_in[l].mag[PW-1:17]};
                lo_reg[0][l]  <= {num_in[l].mag[16:0], 16'b0};
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= (num_in[l].nneg ^ dneg) && (num_in[l].mag != '0);
            end
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s] <= d_reg[s-1];
            end
        end
        for (genvar l = 0; l < LN; l++) begin : g_lane
            logic [PW:0] t_next;
            logic        ge_next;
            assign t_next  = {r_reg[s-1][l], lo_reg[s-1][l][QW-1]};
            assign ge_next = t_next >= {1'b0, d_reg[s-1]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[s][l]   <= ge_next ? PW'(t_next - {1'b0, d_reg[s-1]})
                                             : t_next[PW-1:0];
                    lo_reg[s][l]  <= {lo_reg[s-1][l][QW-2:0], 1'b0};
                    q_reg[s][l]   <= {q_reg[s-1][l][QW-2:0], ge_next};
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
        end
    end

    // Sign, round toward minus infinity and saturate.
    for (genvar l = 0; l < LN; l++) begin : g_out
        logic [QW:0]          qa_next;
        logic signed [CW-1:0] res_next;
        always_comb begin
            qa_next = {1'b0, q_reg[QW][l]} + {{QW{1'b0}}, (r_reg[QW][l] != '0)};
            if (ovf_reg[QW][l]) begin
                res_next = neg_reg[QW][l] ? aptr_pkg::Q16_MIN : aptr_pkg::Q16_MAX;
            end else if (!neg_reg[QW][l]) begin
                res_next = (q_reg[QW][l] > {2'b0, 31'h7FFF_FFFF}) ? aptr_pkg::Q16_MAX
                                                                : q_reg[QW][l][CW-1:0];
            end else begin
                res_next = (qa_next > {2'b0, 32'h8000_0000}) ? aptr_pkg::Q16_MIN
                                                             : CW'(-qa_next);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[l] <= res_next;
            end
        end
        assign quot[l] = quot_reg[l];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= v_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg.sing <= sing_reg[QW];
        end
    end

    assign ctl_out = ctl_reg;

endmodule

`default_nettype wire

// ===== sv/affine_preimage_tile_rect_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Contents
// s_        in         s_tvalid / s_tready       six Q16.16 affine coefficients
// m_        out        m_tvalid / m_tready       covered flag and texel rectangle
// cfg_      in         cfg_valid / cfg_ready     level width / height writes
//
// A new word can enter every cycle while the output is not stalled; the
// 33-stage quotient pipeline yields one quotient bit per stage.
// Reset (aresetn, synchronous, active low) clears all valid bits and sets
// both level sizes to 1024. When the output word is held by m_tready low
// the whole pipeline freezes and s_tready drops, so nothing is lost or
// repeated. Configuration writes are always taken.
module affine_preimage_tile_rect_unit #(
    parameter int unsigned MAX_LEVEL_DIM = aptr_pkg::MAX_LEVEL_DIM_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // u_coef_x, u_coef_y, u_offset, v_coef_x, v_coef_y, v_offset (32 bits each)
    input  wire logic [191:0]                s_tdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // x_start [12:0], y_start [25:13], x_count [39:26], y_count [53:40], zero pad
    output logic [55:0]                      m_tdata,
    // covered
    output logic                             m_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [aptr_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [aptr_pkg::CFG_W-1:0]  cfg_data
);

    localparam int unsigned CW  = aptr_pkg::COEF_W;
    localparam int unsigned PW  = aptr_pkg::PROD_W;
    localparam int unsigned NW  = aptr_pkg::NUM_W;
    localparam int unsigned LN  = aptr_pkg::LANES;
    localparam int unsigned RW  = aptr_pkg::CFG_W;
    localparam int unsigned LW  = $clog2(MAX_LEVEL_DIM + 1);
    localparam int unsigned EW  = (LW > RW) ? LW : RW;
    localparam int unsigned SW  = CW + LW + 1;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_LEVEL_DIM);

    function automatic logic [CW-1:0] abs32(input logic signed [CW-1:0] v);
        abs32 = v[CW-1] ? CW'(~v + 1'b1) : v;
    endfunction

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Level size registers and their effective values.
    logic [RW-1:0] lvl_w_reg, lvl_h_reg;
    logic [LW-1:0] lim_w, lim_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_w_reg <= aptr_pkg::LEVEL_RESET;
            lvl_h_reg <= aptr_pkg::LEVEL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                aptr_pkg::CFG_LEVEL_WIDTH:  lvl_w_reg <= cfg_data;
                aptr_pkg::CFG_LEVEL_HEIGHT: lvl_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (lvl_w_reg == '0)                lim_w = LW'(1);
        else if (EW'(lvl_w_reg) > MAX_E)    lim_w = LW'(MAX_LEVEL_DIM);
        else                                lim_w = LW'(lvl_w_reg);
        if (lvl_h_reg == '0)                lim_h = LW'(1);
        else if (EW'(lvl_h_reg) > MAX_E)    lim_h = LW'(MAX_LEVEL_DIM);
        else                                lim_h = LW'(lvl_h_reg);
    end

    // Stage A: input register.
    logic                 a_v_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, c1_reg, a2_reg, b2_reg, c2_reg;

    // Stage B: products of the coefficients and the largest coefficient.
    logic                 b_v_reg;
    logic signed [PW-1:0] pab_reg, pba_reg, pbc_reg, pbd_reg, pac_reg, pad_reg;
    logic [CW-1:0]        m_reg, m_next;
    logic signed [CW-1:0] ba1_reg, bb1_reg, ba2_reg, bb2_reg;

    // Stage C: determinant, squared magnitude and numerator bases.
    logic                 c_v_reg;
    logic signed [PW-1:0] det_reg;
    logic [PW-1:0]        mm_reg;
    logic signed [PW:0]   bu_reg, bv_reg;
    logic signed [CW-1:0] ca1_reg, cb1_reg, ca2_reg, cb2_reg;

    // Stage D: corner numerators, |det| and the singular threshold.
    logic                 d_v_reg;
    logic signed [NW-1:0] num_reg [LN];
    logic signed [NW-1:0] num_next [LN];
    logic [PW-1:0]        dabs_reg;
    logic                 dneg_reg;
    logic [33:0]          thr_reg;

    // Stage E: numerator magnitudes and the singular flag.
    logic                 e_v_reg, e_sing_reg;
    aptr_pkg::num_t       e_num_reg [LN];
    logic [PW-1:0]        e_dabs_reg;
    logic                 e_dneg_reg;

    aptr_pkg::div_ctl_t   div_in, div_out;
    logic signed [CW-1:0] quot [LN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_comb begin
        logic [CW-1:0] mx0, mx1, mx2;
        mx0    = (abs32(a1_reg) > abs32(b1_reg)) ? abs32(a1_reg) : abs32(b1_reg);
        mx1    = (abs32(a2_reg) > abs32(b2_reg)) ? abs32(a2_reg) : abs32(b2_reg);
        mx2    = (mx0 > mx1) ? mx0 : mx1;
        m_next = (mx2 > 32'd65536) ? mx2 : 32'd65536;
    end

    // Corner k: bit 0 picks U = 1, bit 1 picks V = 1.
    always_comb begin
        logic signed [NW-1:0] su_a1, su_b1, su_a2, su_b2, base_u, base_v;
        su_a1  = {{18{ca1_reg[CW-1]}}, ca1_reg, 16'b0};
        su_b1  = {{18{cb1_reg[CW-1]}}, cb1_reg, 16'b0};
        su_a2  = {{18{ca2_reg[CW-1]}}, ca2_reg, 16'b0};
        su_b2  = {{18{cb2_reg[CW-1]}}, cb2_reg, 16'b0};
        base_u = NW'(bu_reg);
        base_v = NW'(bv_reg);
        for (int k = 0; k < 4; k++) begin
            num_next[k]     = base_u + (k[0] ? su_b2 : '0) - (k[1] ? su_b1 : '0);
            num_next[k + 4] = base_v + (k[1] ? su_a1 : '0) - (k[0] ? su_a2 : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= s_tdata[31:0];
            b1_reg <= s_tdata[63:32];
            c1_reg <= s_tdata[95:64];
            a2_reg <= s_tdata[127:96];
            b2_reg <= s_tdata[159:128];
            c2_reg <= s_tdata[191:160];

            pab_reg <= a1_reg * b2_reg;
            pba_reg <= b1_reg * a2_reg;
            pbc_reg <= b2_reg * c1_reg;
            pbd_reg <= b1_reg * c2_reg;
            pac_reg <= a1_reg * c2_reg;
            pad_reg <= a2_reg * c1_reg;
            m_reg   <= m_next;
            ba1_reg <= a1_reg;
            bb1_reg <= b1_reg;
            ba2_reg <= a2_reg;
            bb2_reg <= b2_reg;

            det_reg <= pab_reg - pba_reg;
            mm_reg  <= PW'(m_reg) * PW'(m_reg);
            bu_reg  <= {pbd_reg[PW-1], pbd_reg} - {pbc_reg[PW-1], pbc_reg};
            bv_reg  <= {pad_reg[PW-1], pad_reg} - {pac_reg[PW-1], pac_reg};
            ca1_reg <= ba1_reg;
            cb1_reg <= bb1_reg;
            ca2_reg <= ba2_reg;
            cb2_reg <= bb2_reg;

            num_reg  <= num_next;
            dabs_reg <= det_reg[PW-1] ? PW'(-det_reg) : det_reg;
            dneg_reg <= det_reg[PW-1];
            thr_reg  <= 34'((mm_reg + PW'(64'h3FFF_FFFF)) >> 30);

            e_sing_reg <= dabs_reg < {30'b0, thr_reg};
            e_dabs_reg <= dabs_reg;
            e_dneg_reg <= dneg_reg;
            for (int l = 0; l < LN; l++) begin
                e_num_reg[l].nneg <= num_reg[l][NW-1];
                e_num_reg[l].mag  <= num_reg[l][NW-1] ? PW'(-num_reg[l])
                                                      : num_reg[l][PW-1:0];
            end
        end
    end

    assign div_in.valid = e_v_reg;
    assign div_in.sing  = e_sing_reg;

    aptr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (div_in),
        .dabs    (e_dabs_reg),
        .dneg    (e_dneg_reg),
        .num_in  (e_num_reg),
        .ctl_out (div_out),
        .quot    (quot)
    );

    // Stage F/G: bounding box of the four corners, as a two-level tree.
    logic                 f_v_reg, f_sing_reg, g_v_reg, g_sing_reg;
    logic signed [CW-1:0] f_mn_reg [4], f_mx_reg [4];
    logic signed [CW-1:0] umin_reg, umax_reg, vmin_reg, vmax_reg;

    // Stage H: box edges scaled by the level size.
    logic                 h_v_reg, h_sing_reg;
    logic signed [SW-1:0] pu0_reg, pu1_reg, pv0_reg, pv1_reg;

    // Stage I: floor / ceil, widen by one texel and clamp.
    logic                 i_v_reg, i_sing_reg;
    logic signed [SW-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [SW-1:0] x0_next, x1_next, y0_next, y1_next;

    // Output register.
    logic                 o_v_reg, o_cov_reg;
    logic [55:0]          o_data_reg;
    logic                 cov_next;
    logic [55:0]          data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            f_v_reg <= div_out.valid;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            o_v_reg <= i_v_reg;
        end
    end

    always_comb begin
        logic signed [SW-1:0] fu, fv, lw, lh;
        lw = SW'(lim_w);
        lh = SW'(lim_h);
        fu = pu0_reg >>> 16;
        fv = pv0_reg >>> 16;
        x0_next = fu - SW'(1);
        y0_next = fv - SW'(1);
        if (x0_next < 0) x0_next = '0;
        if (y0_next < 0) y0_next = '0;
        x1_next = (pu1_reg + SW'(131071)) >>> 16;
        y1_next = (pv1_reg + SW'(131071)) >>> 16;
        if (x1_next > lw) x1_next = lw;
        if (y1_next > lh) y1_next = lh;
    end

    always_comb begin
        logic signed [SW-1:0] dx, dy;
        dx = x1_reg - x0_reg;
        dy = y1_reg - y0_reg;
        cov_next  = !i_sing_reg && (x1_reg > x0_reg) && (y1_reg > y0_reg);
        data_next = '0;
        if (cov_next) begin
            data_next = {2'b0, dy[13:0], dx[13:0], y0_reg[12:0], x0_reg[12:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_sing_reg <= div_out.sing;
            f_mn_reg[0] <= (quot[0] < quot[1]) ? quot[0] : quot[1];
            f_mn_reg[1] <= (quot[2] < quot[3]) ? quot[2] : quot[3];
            f_mx_reg[0] <= (quot[0] > quot[1]) ? quot[0] : quot[1];
            f_mx_reg[1] <= (quot[2] > quot[3]) ? quot[2] : quot[3];
            f_mn_reg[2] <= (quot[4] < quot[5]) ? quot[4] : quot[5];
            f_mn_reg[3] <= (quot[6] < quot[7]) ? quot[6] : quot[7];
            f_mx_reg[2] <= (quot[4] > quot[5]) ? quot[4] : quot[5];
            f_mx_reg[3] <= (quot[6] > quot[7]) ? quot[6] : quot[7];

            g_sing_reg <= f_sing_reg;
            umin_reg <= (f_mn_reg[0] < f_mn_reg[1]) ? f_mn_reg[0] : f_mn_reg[1];
            umax_reg <= (f_mx_reg[0] > f_mx_reg[1]) ? f_mx_reg[0] : f_mx_reg[1];
            vmin_reg <= (f_mn_reg[2] < f_mn_reg[3]) ? f_mn_reg[2] : f_mn_reg[3];
            vmax_reg <= (f_mx_reg[2] > f_mx_reg[3]) ? f_mx_reg[2] : f_mx_reg[3];

            h_sing_reg <= g_sing_reg;
            pu0_reg <= SW'(umin_reg) * SW'($signed({1'b0, lim_w}));
            pu1_reg <= SW'(umax_reg) * SW'($signed({1'b0, lim_w}));
            pv0_reg <= SW'(vmin_reg) * SW'($signed({1'b0, lim_h}));
            pv1_reg <= SW'(vmax_reg) * SW'($signed({1'b0, lim_h}));

            i_sing_reg <= h_sing_reg;
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;

            o_cov_reg  <= cov_next;
            o_data_reg <= data_next;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tuser  = o_cov_reg;
    assign m_tdata  = o_data_reg;

endmodule

`default_nettype wire

// ===== test/affine_preimage_tile_rect_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the affine preimage rectangle unit. A local model
// of the inverse map predicts each output word; results are compared in order.
module affine_preimage_tile_rect_unit_tb;

    typedef struct packed {
        logic        covered;
        logic [12:0] x_start;
        logic [12:0] y_start;
        logic [13:0] x_count;
        logic [13:0] y_count;
    } rect_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [191:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    wire  [55:0]  m_tdata;
    wire          m_tuser;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [aptr_pkg::IDX_W-1:0] cfg_index = '0;
    logic [aptr_pkg::CFG_W-1:0] cfg_data = '0;

    // Model copies of the level registers, updated on each accepted write.
    logic [aptr_pkg::CFG_W-1:0] level_w_mdl = aptr_pkg::LEVEL_RESET;
    logic [aptr_pkg::CFG_W-1:0] level_h_mdl = aptr_pkg::LEVEL_RESET;

    rect_t  rect_queue[$];
    int     mismatches = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    int     words_covered = 0;
    int     stall_left = 0;
    longint cycles = 0;
    bit     stall_enable = 1'b1;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     PIPE_DRAIN  = 60;

    affine_preimage_tile_rect_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, rect_queue.size());
            $display("affine_preimage_tile_rect_unit_tb failed");
            $finish;
        end
    end

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor((p - q) * 2^16 / det), saturated to the Q16.16 range.
    function automatic longint preimage_coord(longint p, longint q, longint det);
        logic        nneg;
        logic [63:0] span;
        logic [79:0] dividend;
        logic [79:0] quo;
        logic [79:0] rem;
        logic [79:0] dmag;
        longint      res;
        nneg = p < q;
        span = nneg ? (q - p) : (p - q);
        dividend = {span, 16'h0};
        dmag = mag_of(det);
        quo = dividend / dmag;
        rem = dividend % dmag;
        if (quo > 80'h100_0000_0000) quo = 80'h100_0000_0000;
        if ((nneg != (det < 0)) && span != 0)
            res = -longint'(quo[63:0] + (rem != 0));
        else
            res = longint'(quo[63:0]);
        if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
        if (res < -64'sh8000_0000) res = -64'sh8000_0000;
        return res;
    endfunction

    function automatic longint level_limit(logic [aptr_pkg::CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > aptr_pkg::MAX_LEVEL_DIM_DEF) return aptr_pkg::MAX_LEVEL_DIM_DEF;
        return longint'(r);
    endfunction

    function automatic longint floor_texel(longint p);
        return p >>> 16;
    endfunction

    function automatic longint ceil_texel(longint p);
        return -((-p) >>> 16);
    endfunction

    // Predicts the texel rectangle covered by the preimage of the unit square.
    function automatic rect_t predict_rect(logic [191:0] w);
        longint a1, b1, c1, a2, b2, c2, det, m, du, dv, tu, tv;
        longint umin, umax, vmin, vmax, lw, lh, x0, x1, y0, y1;
        logic [63:0] thr;
        rect_t r;
        r = '0;
        a1 = longint'($signed(w[31:0]));
        b1 = longint'($signed(w[63:32]));
        c1 = longint'($signed(w[95:64]));
        a2 = longint'($signed(w[127:96]));
        b2 = longint'($signed(w[159:128]));
        c2 = longint'($signed(w[191:160]));
        det = a1 * b2 - b1 * a2;
        m = 65536;
        if (mag_of(a1) > m) m = mag_of(a1);
        if (mag_of(b1) > m) m = mag_of(b1);
        if (mag_of(a2) > m) m = mag_of(a2);
        if (mag_of(b2) > m) m = mag_of(b2);
        thr = (64'(m) * 64'(m) + (64'd1 << 30) - 1) >> 30;
        // A nearly singular map yields an all-zero word.
        if (64'(mag_of(det)) < thr) return r;
        for (int k = 0; k < 4; k++) begin
            du = ((k & 1) ? 65536 : 0) - c1;
            dv = ((k & 2) ? 65536 : 0) - c2;
            tu = preimage_coord(b2 * du, b1 * dv, det);
            tv = preimage_coord(a1 * dv, a2 * du, det);
            if (k == 0 || tu < umin) umin = tu;
            if (k == 0 || tu > umax) umax = tu;
            if (k == 0 || tv < vmin) vmin = tv;
            if (k == 0 || tv > vmax) vmax = tv;
        end
        lw = level_limit(level_w_mdl);
        lh = level_limit(level_h_mdl);
        x0 = floor_texel(umin * lw) - 1;
        x1 = ceil_texel(umax * lw) + 1;
        y0 = floor_texel(vmin * lh) - 1;
        y1 = ceil_texel(vmax * lh) + 1;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > lw) x1 = lw;
        if (y1 > lh) y1 = lh;
        // An empty clamped box also gives an all-zero word.
        if (x1 <= x0 || y1 <= y0) return r;
        r.covered = 1'b1;
        r.x_start = x0[12:0];
        r.y_start = y0[12:0];
        r.x_count = 14'(x1 - x0);
        r.y_count = 14'(y1 - y0);
        return r;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    // Output stalls come in runs of random length, mostly short.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                if (stall_enable && $urandom_range(0, 3) == 0) stall_left <= gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        rect_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[12:0], m_tdata[25:13], m_tdata[39:26], m_tdata[53:40]};
            if (rect_queue.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = rect_queue.pop_front();
                if (got.covered != want.covered)
                    report_mismatch("covered", got.covered, want.covered);
                if (got.x_start != want.x_start)
                    report_mismatch("x_start", got.x_start, want.x_start);
                if (got.y_start != want.y_start)
                    report_mismatch("y_start", got.y_start, want.y_start);
                if (got.x_count != want.x_count)
                    report_mismatch("x_count", got.x_count, want.x_count);
                if (got.y_count != want.y_count)
                    report_mismatch("y_count", got.y_count, want.y_count);
                if (want.covered) words_covered++;
            end
            words_checked++;
        end
    end

    // Sends one coefficient word; the expectation is queued when it is taken.
    // The valid stays high afterwards so that words can follow back to back;
    // the next gap or the drain drops it.
    task automatic send_word(logic [191:0] w);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rect_queue.push_back(predict_rect(w));
        words_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [191:0] pack_rows(longint a1, longint b1, longint c1,
                                               longint a2, longint b2, longint c2);
        return {c2[31:0], b2[31:0], a2[31:0], c1[31:0], b1[31:0], a1[31:0]};
    endfunction

    // Waits for every result and lets the pipeline settle before a write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rect_queue.size() != 0) @(negedge aclk);
        repeat (PIPE_DRAIN) @(negedge aclk);
    endtask

    task automatic write_level(logic [aptr_pkg::IDX_W-1:0] idx,
                               logic [aptr_pkg::CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == aptr_pkg::CFG_LEVEL_WIDTH) level_w_mdl = val;
        else if (idx == aptr_pkg::CFG_LEVEL_HEIGHT) level_h_mdl = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Random coefficient near a typical scale, sometimes full range.
    function automatic longint rand_coef();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return longint'($signed($urandom_range(0, 32'h0004_0000))) - 32'h0002_0000;
        if (sel < 8) return longint'($signed($urandom()));
        return longint'($signed($urandom_range(0, 64))) - 32;
    endfunction

    function automatic longint rand_offset();
        if ($urandom_range(0, 3) == 0) return longint'($signed($urandom()));
        return longint'($signed($urandom_range(0, 32'h0006_0000))) - 32'h0003_0000;
    endfunction

    task automatic test_directed();
        longint one;
        one = 65536;
        // Identity and scaled identity maps.
        send_word(pack_rows(one, 0, 0, 0, one, 0));
        send_word(pack_rows(2 * one, 0, 0, 0, 2 * one, 0));
        send_word(pack_rows(one / 4, 0, -one / 8, 0, one / 4, one / 8));
        // Rotation and shear.
        send_word(pack_rows(0, one, 0, -one, 0, one));
        send_word(pack_rows(one, one / 2, 0, 0, one, 0));
        // Singular maps: zero, rank one, tiny determinant; then a map squashed in one axis.
        send_word(pack_rows(0, 0, 0, 0, 0, 0));
        send_word(pack_rows(one, one, 0, one, one, 0));
        send_word(pack_rows(1, 0, 0, 0, 1, 0));
        send_word(pack_rows(one, 0, 0, 0, 2, 0));
        // Field extremes, then a small scale and a negated identity.
        send_word(pack_rows(-64'sh8000_0000, 0, 64'sh7FFF_FFFF, 0, 64'sh7FFF_FFFF, -64'sh8000_0000));
        send_word(pack_rows(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000,
                            -64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
        send_word(pack_rows(256, 0, 0, 0, 256, 0));
        send_word(pack_rows(-one, 0, 0, 0, -one, 0));
        // Preimage entirely off the level gives an empty rectangle.
        send_word(pack_rows(one, 0, 10 * one, 0, one, 0));
        send_word(pack_rows(one, 0, -10 * one, 0, one, -10 * one));
        send_word(pack_rows(-1, -1, -1, -1, 1, 0));
        send_word(pack_rows(64'sh5555_5555, -64'sh2AAA_AAAB, 64'sh5555_5555,
                            64'sh2AAA_AAAA, 64'sh5555_5555, -64'sh5555_5556));
    endtask

    task automatic test_random(int n);
        longint a1, b1, a2, b2;
        for (int i = 0; i < n; i++) begin
            a1 = rand_coef(); b1 = rand_coef(); a2 = rand_coef(); b2 = rand_coef();
            // Some words are built as near-singular pairs.
            if ($urandom_range(0, 15) == 0) begin
                a2 = a1; b2 = b1 + $urandom_range(0, 3);
            end
            send_word(pack_rows(a1, b1, rand_offset(), a2, b2, rand_offset()));
        end
    endtask

    task automatic test_level(logic [aptr_pkg::CFG_W-1:0] w,
                              logic [aptr_pkg::CFG_W-1:0] h, int n);
        drain();
        write_level(aptr_pkg::CFG_LEVEL_WIDTH, w);
        write_level(aptr_pkg::CFG_LEVEL_HEIGHT, h);
        test_directed();
        test_random(n);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(250);
        // Out-of-range sizes act as the nearest legal size.
        test_level(14'd8192, 14'd1, 120);
        test_level(14'd0, 14'h3FFF, 120);
        test_level(14'd37, 14'd8191, 120);
        stall_enable = 1'b0;
        test_level(14'd1, 14'd8192, 100);
        stall_enable = 1'b1;
        test_level(14'd1024, 14'd300, 150);
        drain();
        $display("sent %0d coefficient words over 6 level settings", words_sent);
        $display("checked %0d results, %0d of them covered", words_checked, words_covered);
        if (mismatches == 0) begin
            $display("affine_preimage_tile_rect_unit_tb passed");
        end else begin
            $display("affine_preimage_tile_rect_unit_tb failed");
        end
        $finish;
    end

endmodule
